>>> rtl/trfr_pkg.sv
// Shared types, widths and codes for the tile range lookup block.
package trfr_pkg;

    localparam int DIM_W      = 16;
    localparam int COORD_W    = 17;
    localparam int RANK_W     = 16;
    localparam int DIV_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int GCNT_W     = 3;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 72;
    localparam int M_TUSER_W  = 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TRAVERSAL_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_TOTAL      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_TOTAL   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GROUP_COUNT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GROUP_FIRSTS   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GROUP_SECONDS  = 3'd5;

    localparam logic [COORD_W-1:0] NO_TILE = '1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SUM,
        ST_CLAMP,
        ST_WALK,
        ST_TILES,
        ST_TEST,
        ST_RANK_GO,
        ST_RANK_WAIT,
        ST_CUT_GO,
        ST_CUT_WAIT,
        ST_CUT_MUL,
        ST_CUT_END,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

>>> rtl/trfr_div.sv
// Iterative restoring divider, one quotient bit per cycle.
module trfr_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [trfr_pkg::DIV_W-1:0] dividend,
    input  logic [trfr_pkg::DIV_W-1:0] divisor,
    output logic [trfr_pkg::DIV_W-1:0] quotient,
    output logic [trfr_pkg::DIV_W-1:0] remainder,
    output trfr_pkg::div_status_t      status
);
    import trfr_pkg::*;

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DIV_W:0]   trial;
    logic [DIV_W:0]   diff;

    always_comb begin
        trial     = {rem_reg, quo_reg[DIV_W-1]};
        diff      = trial - {1'b0, dvs_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = CNT_W'(DIV_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // shift in one dividend bit, subtract when it fits
            if (!diff[DIV_W]) begin
                rem_next = diff[DIV_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b1};
            end else begin
                rem_next = trial[DIV_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign quotient    = quo_reg;
    assign remainder   = rem_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

>>> rtl/tile_range_for_rank.sv
// Top level: rank to tile rectangle lookup with a shared divider and multiplier.
//
//  Channel   Dir  Payload                                              Handshake
//  s_        in   tdata[15:0] rank                                     tvalid/tready
//  m_        out  tdata: row_start, row_end, col_start, col_end (17b)  tvalid/tready
//                 tuser[0] found
//  cfg_      in   cfg_index selects register, cfg_wr_data value        cfg_wr_en
//
// A rank that owns a tile makes three passes through the shared divider: one to split
// the rank within its group and one for each of the two balanced cuts.
// s_tready is high only while the sequencer is idle; a finished result sits in
// the output register until taken, and the next rank may be accepted meanwhile.
// Reset is synchronous and active low; it restores the register defaults.
module tile_range_for_rank #(
    parameter int MAX_GROUPS       = 4,
    parameter int GROUP_FIELD_BITS = 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration write port
    input  logic                            cfg_wr_en,
    input  logic [trfr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [trfr_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    // rank in; tdata: [15:0] rank
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [trfr_pkg::S_TDATA_W-1:0]  s_tdata,
    // tile out; tdata: [16:0] row_start, [33:17] row_end, [50:34] col_start,
    // [67:51] col_end, [71:68] zero
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [trfr_pkg::M_TDATA_W-1:0]  m_tdata,
    // tuser: [0] found
    output logic [trfr_pkg::M_TUSER_W-1:0]  m_tuser
);
    import trfr_pkg::*;

    localparam int FW    = GROUP_FIELD_BITS;
    localparam int GW    = $clog2(MAX_GROUPS + 1);
    localparam int SUM_W = GROUP_FIELD_BITS + $clog2(MAX_GROUPS + 1);

    // Pick group field g out of a packed register; zero or out of reach reads as one.
    function automatic logic [FW-1:0] pick(input logic [CFG_DATA_W-1:0] packed_val,
                                           input logic [GW-1:0] g);
        int           amt;
        logic [FW-1:0] v;
        amt = int'(g) * GROUP_FIELD_BITS;
        if (amt >= CFG_DATA_W) begin
            v = FW'(1);
        end else begin
            v = FW'(packed_val >> amt);
            if (v == '0) begin
                v = FW'(1);
            end
        end
        return v;
    endfunction

    // configuration registers
    logic                  mode_reg;
    logic [DIM_W-1:0]      row_total_reg;
    logic [DIM_W-1:0]      column_total_reg;
    logic [GCNT_W-1:0]     group_count_reg;
    logic [CFG_DATA_W-1:0] firsts_reg;
    logic [CFG_DATA_W-1:0] seconds_reg;

    // sequencer state and datapath
    state_t              state_reg, state_next;
    logic [RANK_W-1:0]   rank_reg, rank_next;
    logic [GW-1:0]       g_reg, g_next;
    logic [SUM_W-1:0]    acc_reg, acc_next;
    logic [DIM_W-1:0]    otot_reg, otot_next;
    logic [DIM_W-1:0]    base_reg, base_next;
    logic [DIM_W-1:0]    cnt_reg, cnt_next;
    logic [DIM_W-1:0]    split_reg, split_next;
    logic [2*DIM_W-1:0]  prod_reg, prod_next;
    logic [DIM_W-1:0]    kout_reg, kout_next;
    logic [DIM_W-1:0]    kin_reg, kin_next;
    logic [DIM_W-1:0]    w_reg, w_next;
    logic [DIM_W-1:0]    rem_reg, rem_next;
    logic                cut_inner_reg, cut_inner_next;
    logic [DIM_W-1:0]    os_reg, os_next, oe_reg, oe_next;
    logic [DIM_W-1:0]    is_reg, is_next, ie_reg, ie_next;
    logic                hit_reg, hit_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                found_reg, found_next;

    // combinational helpers
    logic [GW-1:0]       groups;
    logic [DIM_W-1:0]    outer_dim, inner_dim;
    logic [FW-1:0]       ofield, ifield;
    logic [DIM_W-1:0]    left;
    logic [DIM_W-1:0]    k_sel, len_sel, n_sel;
    logic [DIM_W-1:0]    mul_a, mul_b;
    logic                k_lt_rem;
    logic [DIM_W:0]      cut_s, cut_e;
    logic [COORD_W-1:0]  r_s, r_e, c_s, c_e;

    // shared divider
    logic                div_start;
    logic [DIV_W-1:0]    div_a, div_b, div_q, div_r;
    div_status_t         div_st;

    trfr_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_a),
        .divisor   (div_b),
        .quotient  (div_q),
        .remainder (div_r),
        .status    (div_st)
    );

    // Clamp group count to [1, MAX_GROUPS]
    always_comb begin
        if (group_count_reg == '0) begin
            groups = GW'(1);
        end else if (32'(group_count_reg) > 32'(MAX_GROUPS)) begin
            groups = GW'(MAX_GROUPS);
        end else begin
            groups = GW'(group_count_reg);
        end
    end

    assign outer_dim = mode_reg ? row_total_reg : column_total_reg;
    assign inner_dim = mode_reg ? column_total_reg : row_total_reg;
    // Rows outer: first is block count, second the splits; columns outer swaps them
    assign ofield    = mode_reg ? pick(firsts_reg, g_reg) : pick(seconds_reg, g_reg);
    assign ifield    = mode_reg ? pick(seconds_reg, g_reg) : pick(firsts_reg, g_reg);
    assign left      = otot_reg - base_reg;

    // Operand select for the balanced cut in progress
    assign k_sel   = cut_inner_reg ? kin_reg   : kout_reg;
    assign len_sel = cut_inner_reg ? inner_dim : outer_dim;
    assign n_sel   = cut_inner_reg ? split_reg : otot_reg;

    assign mul_a = (state_reg == ST_TILES) ? cnt_reg   : k_sel;
    assign mul_b = (state_reg == ST_TILES) ? split_reg : w_reg;

    assign div_start = (state_reg == ST_RANK_GO) || (state_reg == ST_CUT_GO);
    assign div_a     = (state_reg == ST_RANK_GO) ? rank_reg  : len_sel;
    assign div_b     = (state_reg == ST_RANK_GO) ? split_reg : n_sel;

    // start = k*w + min(k, rem); end = start + w + (k < rem) - 1
    assign k_lt_rem = k_sel < rem_reg;
    assign cut_s    = (DIM_W+1)'(prod_reg[DIM_W-1:0]) +
                      (DIM_W+1)'(k_lt_rem ? k_sel : rem_reg);
    assign cut_e    = cut_s + (DIM_W+1)'(w_reg) + (DIM_W+1)'(k_lt_rem) - (DIM_W+1)'(1);

    // Map outer/inner bounds to rows/columns
    assign r_s = hit_reg ? COORD_W'(mode_reg ? os_reg : is_reg) : NO_TILE;
    assign r_e = hit_reg ? COORD_W'(mode_reg ? oe_reg : ie_reg) : NO_TILE;
    assign c_s = hit_reg ? COORD_W'(mode_reg ? is_reg : os_reg) : NO_TILE;
    assign c_e = hit_reg ? COORD_W'(mode_reg ? ie_reg : oe_reg) : NO_TILE;

    // Sequencer: next state and datapath
    always_comb begin
        state_next     = state_reg;
        rank_next      = rank_reg;
        g_next         = g_reg;
        acc_next       = acc_reg;
        otot_next      = otot_reg;
        base_next      = base_reg;
        cnt_next       = cnt_reg;
        split_next     = split_reg;
        prod_next      = prod_reg;
        kout_next      = kout_reg;
        kin_next       = kin_reg;
        w_next         = w_reg;
        rem_next       = rem_reg;
        cut_inner_next = cut_inner_reg;
        os_next        = os_reg;
        oe_next        = oe_reg;
        is_next        = is_reg;
        ie_next        = ie_reg;
        hit_next       = hit_reg;
        m_tvalid_next  = m_tvalid_reg;
        m_tdata_next   = m_tdata_reg;
        found_next     = found_reg;

        // drop the result once the downstream takes it
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    rank_next = s_tdata[RANK_W-1:0];
                    g_next    = '0;
                    acc_next  = '0;
                    hit_next  = 1'b0;
                    // an empty matrix has no tiles at all
                    if (row_total_reg == '0 || column_total_reg == '0) begin
                        state_next = ST_OUT;
                    end else begin
                        state_next = ST_SUM;
                    end
                end
            end
            ST_SUM: begin
                acc_next = acc_reg + SUM_W'(ofield);
                if (g_reg == groups - GW'(1)) begin
                    state_next = ST_CLAMP;
                end else begin
                    g_next = g_reg + GW'(1);
                end
            end
            ST_CLAMP: begin
                otot_next  = (32'(acc_reg) > 32'(outer_dim)) ? outer_dim
                                                             : DIM_W'(acc_reg);
                g_next     = '0;
                base_next  = '0;
                state_next = ST_WALK;
            end
            ST_WALK: begin
                if (g_reg == groups || base_reg >= otot_reg) begin
                    state_next = ST_OUT;
                end else begin
                    cnt_next   = (32'(ofield) > 32'(left)) ? left : DIM_W'(ofield);
                    split_next = (32'(ifield) > 32'(inner_dim)) ? inner_dim
                                                               : DIM_W'(ifield);
                    state_next = ST_TILES;
                end
            end
            ST_TILES: begin
                prod_next  = mul_a * mul_b;
                state_next = ST_TEST;
            end
            ST_TEST: begin
                if (32'(rank_reg) < prod_reg) begin
                    state_next = ST_RANK_GO;
                end else begin
                    // skip this group's tiles
                    rank_next  = rank_reg - prod_reg[RANK_W-1:0];
                    base_next  = base_reg + cnt_reg;
                    g_next     = g_reg + GW'(1);
                    state_next = ST_WALK;
                end
            end
            ST_RANK_GO: begin
                state_next = ST_RANK_WAIT;
            end
            ST_RANK_WAIT: begin
                if (div_st.done) begin
                    kout_next      = base_reg + div_q;
                    kin_next       = div_r;
                    cut_inner_next = 1'b0;
                    state_next     = ST_CUT_GO;
                end
            end
            ST_CUT_GO: begin
                state_next = ST_CUT_WAIT;
            end
            ST_CUT_WAIT: begin
                if (div_st.done) begin
                    w_next     = div_q;
                    rem_next   = div_r;
                    state_next = ST_CUT_MUL;
                end
            end
            ST_CUT_MUL: begin
                prod_next  = mul_a * mul_b;
                state_next = ST_CUT_END;
            end
            ST_CUT_END: begin
                if (!cut_inner_reg) begin
                    os_next        = cut_s[DIM_W-1:0];
                    oe_next        = cut_e[DIM_W-1:0];
                    cut_inner_next = 1'b1;
                    state_next     = ST_CUT_GO;
                end else begin
                    is_next    = cut_s[DIM_W-1:0];
                    ie_next    = cut_e[DIM_W-1:0];
                    hit_next   = 1'b1;
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                // hold until the output register is free
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {{(M_TDATA_W - 4*COORD_W){1'b0}}, c_e, c_s, r_e, r_s};
                    found_next    = hit_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg         <= 1'b0;
            row_total_reg    <= DIM_W'(1);
            column_total_reg <= DIM_W'(1);
            group_count_reg  <= GCNT_W'(3);
            firsts_reg       <= CFG_DATA_W'(197121);
            seconds_reg      <= CFG_DATA_W'(197121);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_TRAVERSAL_MODE: mode_reg         <= cfg_wr_data[0];
                REG_ROW_TOTAL:      row_total_reg    <= cfg_wr_data[DIM_W-1:0];
                REG_COLUMN_TOTAL:   column_total_reg <= cfg_wr_data[DIM_W-1:0];
                REG_GROUP_COUNT:    group_count_reg  <= cfg_wr_data[GCNT_W-1:0];
                REG_GROUP_FIRSTS:   firsts_reg       <= cfg_wr_data;
                REG_GROUP_SECONDS:  seconds_reg      <= cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        rank_reg      <= rank_next;
        g_reg         <= g_next;
        acc_reg       <= acc_next;
        otot_reg      <= otot_next;
        base_reg      <= base_next;
        cnt_reg       <= cnt_next;
        split_reg     <= split_next;
        prod_reg      <= prod_next;
        kout_reg      <= kout_next;
        kin_reg       <= kin_next;
        w_reg         <= w_next;
        rem_reg       <= rem_next;
        cut_inner_reg <= cut_inner_next;
        os_reg        <= os_next;
        oe_reg        <= oe_next;
        is_reg        <= is_next;
        ie_reg        <= ie_next;
        hit_reg       <= hit_next;
        m_tdata_reg   <= m_tdata_next;
        found_reg     <= found_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = found_reg;

endmodule

>>> rtl/trfr_checker.sv
// Port-level assertions for the tile range lookup, bound to the top level.
module trfr_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [trfr_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [trfr_pkg::M_TUSER_W-1:0] m_tuser
);
    import trfr_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // one rank at a time: input closes after a transfer
    a_in_close: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input still open after a transfer");

    // no tile: every coordinate is -1
    a_miss_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata[4*COORD_W-1:0] == {4{NO_TILE}})
        else $error("missing tile not reported as all -1");

    // a tile has ordered bounds, with row_start and col_end non-negative
    a_hit_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |->
            !m_tdata[COORD_W-1] && !m_tdata[4*COORD_W-1] &&
            m_tdata[COORD_W-1:0] <= m_tdata[2*COORD_W-1:COORD_W] &&
            m_tdata[3*COORD_W-1:2*COORD_W] <= m_tdata[4*COORD_W-1:3*COORD_W])
        else $error("tile bounds out of order");

endmodule

bind tile_range_for_rank trfr_checker u_trfr_checker (.*);

>>> sim/tile_range_checker.sv
// Tile range checker: predicts each rank lookup and compares the returned tile.
module tile_range_checker #(
    parameter int MAX_GROUPS       = 4,
    parameter int GROUP_FIELD_BITS = 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [trfr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [trfr_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [trfr_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [trfr_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic [trfr_pkg::M_TUSER_W-1:0]  m_tuser,
    output int                              fail_count,
    output int                              pending
);
    import trfr_pkg::*;

    typedef struct packed {
        logic [COORD_W-1:0] row_start;
        logic [COORD_W-1:0] row_end;
        logic [COORD_W-1:0] col_start;
        logic [COORD_W-1:0] col_end;
        logic               found;
    } tile_t;

    tile_t tiles_due[$];
    int    errors = 0;

    logic                traversal;
    logic [DIM_W-1:0]    rows;
    logic [DIM_W-1:0]    cols;
    logic [GCNT_W-1:0]   group_sel;
    logic [31:0]         firsts;
    logic [31:0]         seconds;

    function automatic longint unsigned group_value(logic [31:0] packed_v, int g);
        longint unsigned shift_amt;
        longint unsigned v;
        shift_amt = 64'(g * GROUP_FIELD_BITS);
        if (shift_amt >= 64)
            return 1;
        v = (64'(packed_v) >> shift_amt) & ((64'd1 << GROUP_FIELD_BITS) - 1);
        return (v == 0) ? 1 : v;
    endfunction

    function automatic void balanced_span(input longint unsigned len, parts, k,
                                          output longint unsigned lo, hi);
        longint unsigned w;
        longint unsigned rem;
        w   = len / parts;
        rem = len % parts;
        lo  = k * w + ((k < rem) ? k : rem);
        hi  = lo + w + ((k < rem) ? 1 : 0) - 1;
    endfunction

    function automatic tile_t locate_tile(logic [RANK_W-1:0] rank_in);
        longint unsigned rank, outer_dim, inner_dim, outer_total, base;
        longint unsigned cnt, split, tiles, outer_idx, inner_idx, inner_n;
        longint unsigned out_lo, out_hi, in_lo, in_hi;
        int              groups;
        bit              hit;
        tile_t           t;
        rank        = 64'(rank_in);
        groups      = 32'(group_sel);
        outer_total = 0;
        base        = 0;
        hit         = 0;
        outer_idx   = 0;
        inner_idx   = 0;
        inner_n     = 1;
        if (groups == 0)
            groups = 1;
        if (groups > MAX_GROUPS)
            groups = MAX_GROUPS;
        outer_dim = 64'(traversal ? rows : cols);
        inner_dim = 64'(traversal ? cols : rows);
        if (outer_dim != 0 && inner_dim != 0) begin
            for (int g = 0; g < groups; g++)
                outer_total += traversal ? group_value(firsts, g) : group_value(seconds, g);
            if (outer_total > outer_dim)
                outer_total = outer_dim;
            for (int g = 0; g < groups && !hit && base < outer_total; g++) begin
                cnt   = traversal ? group_value(firsts, g) : group_value(seconds, g);
                split = traversal ? group_value(seconds, g) : group_value(firsts, g);
                if (cnt > outer_total - base)
                    cnt = outer_total - base;
                if (split > inner_dim)
                    split = inner_dim;
                tiles = cnt * split;
                if (rank < tiles) begin
                    outer_idx = base + rank / split;
                    inner_idx = rank % split;
                    inner_n   = split;
                    hit       = 1;
                end else begin
                    rank -= tiles;
                    base += cnt;
                end
            end
        end
        if (hit) begin
            balanced_span(outer_dim, outer_total, outer_idx, out_lo, out_hi);
            balanced_span(inner_dim, inner_n, inner_idx, in_lo, in_hi);
            if (traversal) begin
                t.row_start = out_lo[COORD_W-1:0];
                t.row_end   = out_hi[COORD_W-1:0];
                t.col_start = in_lo[COORD_W-1:0];
                t.col_end   = in_hi[COORD_W-1:0];
            end else begin
                t.row_start = in_lo[COORD_W-1:0];
                t.row_end   = in_hi[COORD_W-1:0];
                t.col_start = out_lo[COORD_W-1:0];
                t.col_end   = out_hi[COORD_W-1:0];
            end
            t.found = 1'b1;
        end else begin
            t.row_start = NO_TILE;
            t.row_end   = NO_TILE;
            t.col_start = NO_TILE;
            t.col_end   = NO_TILE;
            t.found     = 1'b0;
        end
        return t;
    endfunction

    task automatic check_field(string name, logic [COORD_W-1:0] want, logic [COORD_W-1:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s expected %h got %h", $time, name, want, got);
        end
    endtask

    always @(posedge aclk) begin
        tile_t want;
        if (!aresetn) begin
            traversal = 1'b0;
            rows      = 16'd1;
            cols      = 16'd1;
            group_sel = 3'd3;
            firsts    = 32'h0003_0201;
            seconds   = 32'h0003_0201;
            tiles_due.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (tiles_due.size() == 0) begin
                    errors++;
                    $display("%0t: tile with no rank pending, expected none got tdata %h tuser %h",
                             $time, m_tdata, m_tuser);
                end else begin
                    want = tiles_due.pop_front();
                    check_field("row_start", want.row_start, m_tdata[COORD_W-1:0]);
                    check_field("row_end", want.row_end, m_tdata[2*COORD_W-1:COORD_W]);
                    check_field("col_start", want.col_start, m_tdata[3*COORD_W-1:2*COORD_W]);
                    check_field("col_end", want.col_end, m_tdata[4*COORD_W-1:3*COORD_W]);
                    check_field("found", COORD_W'(want.found), COORD_W'(m_tuser[0]));
                end
            end
            if (s_tvalid && s_tready)
                tiles_due = {tiles_due, locate_tile(s_tdata[RANK_W-1:0])};
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_TRAVERSAL_MODE: traversal = cfg_wr_data[0];
                    REG_ROW_TOTAL:      rows      = cfg_wr_data[DIM_W-1:0];
                    REG_COLUMN_TOTAL:   cols      = cfg_wr_data[DIM_W-1:0];
                    REG_GROUP_COUNT:    group_sel = cfg_wr_data[GCNT_W-1:0];
                    REG_GROUP_FIRSTS:   firsts    = cfg_wr_data[31:0];
                    REG_GROUP_SECONDS:  seconds   = cfg_wr_data[31:0];
                    default: ;
                endcase
            end
        end
        pending    <= tiles_due.size();
        fail_count <= errors;
    end

endmodule

>>> sim/tile_range_for_rank_test.sv
// Testbench top: drives rank lookups and configuration into the tile range block.
module tile_range_for_rank_test;
    import trfr_pkg::*;

    // indexes past the register file; writes to them must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

    localparam int RANDOM_PHASES = 12;
    localparam int RANKS_PER_PHASE = 50;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wr_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;    // [15:0] rank
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;    // row_start, row_end, col_start, col_end, zero pad
    logic [M_TUSER_W-1:0]  m_tuser;    // [0] found

    int          fail_count;
    int          pending;
    bit          quiet;       // no idling on either side once set
    int unsigned rank_span;   // rough tile count of the current setting

    tile_range_for_rank uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    tile_range_checker checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Hard stop: the whole run, stalls on both sides included, stays far below this.
    initial begin
        #6_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Result side: mix random ready stretches and stall bursts, then hold ready
    // high for the quiet tail of the run.
    initial begin : sink_pacing
        int unsigned hold;
        bit          stalling;
        hold     = 0;
        stalling = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (quiet) begin
                m_tready <= 1'b1;
            end else begin
                if (hold == 0) begin
                    stalling = ($urandom_range(0, 2) == 0);
                    hold = stalling ? $urandom_range(1, 19) : $urandom_range(1, 40);
                end
                hold--;
                m_tready <= !stalling;
            end
        end
    end

    // Sum of first*second over all four groups, zero counted as one; clamps and
    // the group count are ignored, so this only aims ranks near the tile edge.
    function automatic int unsigned tile_estimate(logic [31:0] firsts, logic [31:0] seconds);
        int unsigned sum;
        int unsigned a;
        int unsigned b;
        sum = 0;
        for (int g = 0; g < 4; g++) begin
            a = 32'(firsts[8*g +: 8]);
            b = 32'(seconds[8*g +: 8]);
            if (a == 0) a = 1;
            if (b == 0) b = 1;
            sum += a * b;
        end
        return (sum > 65535) ? 65535 : sum;
    endfunction

    // Mostly small matrices; now and then zero, mid-size or full 16-bit.
    // Upper word is junk that the register must drop.
    function automatic logic [31:0] pick_dim();
        logic [15:0] dim;
        logic [15:0] junk;
        junk = 16'($urandom);
        case ($urandom_range(0, 24))
            0:       dim = 16'd0;
            1:       dim = 16'hFFFF;
            2:       dim = 16'($urandom_range(32768, 65535));
            3, 4:    dim = 16'($urandom_range(41, 3000));
            default: dim = 16'($urandom_range(1, 40));
        endcase
        return {junk, dim};
    endfunction

    function automatic logic [31:0] pick_groups();
        logic [31:0] packed_v;
        for (int g = 0; g < 4; g++) begin
            case ($urandom_range(0, 9))
                0:       packed_v[8*g +: 8] = 8'd0;
                1:       packed_v[8*g +: 8] = 8'($urandom_range(0, 255));
                2:       packed_v[8*g +: 8] = 8'hFF;
                default: packed_v[8*g +: 8] = 8'($urandom_range(1, 6));
            endcase
        end
        return packed_v;
    endfunction

    // Aim at the tile range, the first few tiles, the edge past the last tile,
    // and the whole 16-bit space.
    function automatic logic [15:0] pick_rank();
        int v;
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7, 8, 9: v = $urandom_range(0, rank_span);
            10, 11, 12, 13, 14:           v = $urandom_range(0, 15);
            15, 16: begin
                v = int'(rank_span) + int'($urandom_range(0, 8)) - 4;
                if (v < 0) v = 0;
                if (v > 65535) v = 65535;
            end
            default:                      v = $urandom_range(0, 65535);
        endcase
        return v[15:0];
    endfunction

    // Present one rank, optionally after a sender gap, and hold it until the transfer.
    // Return at the falling edge after the transfer with tvalid still high.
    task automatic send_rank(input logic [15:0] rank);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= rank;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // Drop tvalid and wait for every outstanding tile to come back.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Write the full register set with the block idle.
    task automatic load_config(input logic [31:0] mode, rows, cols, groups,
                               input logic [31:0] firsts, seconds);
        drain();
        write_reg(REG_TRAVERSAL_MODE, mode);
        write_reg(REG_ROW_TOTAL, rows);
        write_reg(REG_COLUMN_TOTAL, cols);
        write_reg(REG_GROUP_COUNT, groups);
        write_reg(REG_GROUP_FIRSTS, firsts);
        write_reg(REG_GROUP_SECONDS, seconds);
        rank_span = tile_estimate(firsts, seconds);
    endtask

    initial begin
        int phase;
        int n;
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_index   = '0;
        cfg_wr_data = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        quiet       = 1'b0;
        rank_span   = tile_estimate(32'h0003_0201, 32'h0003_0201);
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset defaults: 1x1 matrix, only rank 0 owns a tile
        send_rank(16'd0);
        send_rank(16'd1);
        send_rank(16'hFFFF);

        // zero group fields count as one; outer blocks 3+4+1 clamp to 7 columns,
        // so the third group's block drops out
        load_config(32'd0, 32'd10, 32'd7, 32'd3, 32'h0003_0002, 32'h0500_0403);
        send_rank(16'd0);
        send_rank(16'd5);
        send_rank(16'd6);
        send_rank(16'd9);
        send_rank(16'd10);
        send_rank(16'hFFFF);

        // largest matrix, rows outer, all fields at maximum, group count saturated
        load_config(32'd1, 32'hFFFF, 32'hFFFF, 32'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_rank(16'd0);
        send_rank(16'd255);
        send_rank(16'd12345);
        send_rank(16'hFFFF);

        // zero column count: no tiles at all; group count zero acts as one group
        load_config(32'd0, 32'd3, 32'd0, 32'd0, 32'h0000_00C8, 32'h0000_0002);
        send_rank(16'd0);

        // restore columns: 200 row splits clamp to 3 rows, 2 column blocks
        drain();
        write_reg(REG_COLUMN_TOTAL, 32'd5);
        send_rank(16'd0);
        send_rank(16'd5);
        send_rank(16'd6);

        // writes to unused indexes must not alias onto real registers
        drain();
        write_reg(REG_SPARE_A, 32'h0000_0000);
        write_reg(REG_SPARE_B, 32'h0000_0000);
        send_rank(16'd3);
        send_rank(16'd4);

        // random settings; the last phase runs with no idling on either side
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            if (phase == RANDOM_PHASES - 1)
                quiet = 1'b1;
            load_config($urandom, pick_dim(), pick_dim(), $urandom, pick_groups(),
                        pick_groups());
            for (n = 0; n < RANKS_PER_PHASE; n++) begin
                // hold off the sender until the block has returned everything
                if (n == RANKS_PER_PHASE / 2 && phase % 3 == 1)
                    drain();
                send_rank(pick_rank());
            end
        end

        // let the last tiles come back, then watch for stray transfers
        drain();
        repeat (120) @(negedge aclk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
